@@ hw/rtl/blri_pkg.sv @@
package blri_pkg;

    localparam logic [31:0] LCG_MUL     = 32'd1103515245;
    localparam logic [31:0] LCG_ADD     = 32'd12345;
    localparam logic [30:0] BOUND_LIMIT = 31'h4000_0000;
    localparam int          SIGN_BIT    = 30;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_STEP,
        S_CHECK,
        S_SIGN,
        S_DONE
    } blri_state_t;

    // Right shift that leaves the top n bits of a 31-bit word, where n is the
    // smallest count of at least one with 2^n not below the bound.
    function automatic logic [4:0] shift_for(input logic [30:0] bound);
        logic [30:0] bm1;
        logic [4:0]  hl;
        bm1 = bound - 31'd1;
        hl  = 5'd1;
        for (int i = 1; i < 31; i++)
        begin
            if (bm1[i])
            begin
                hl = 5'(i + 1);
            end
        end
        return 5'd31 - hl;
    endfunction

endpackage

@@ hw/rtl/bounded_lcg_random_int_top.sv @@
// Each request carries a bound and returns one random integer whose magnitude
// is at most that bound, with a random sign; bounds above 2^30 are treated as
// 2^30. A 32-bit linear congruential seed, reset to one, is advanced by a
// single multiply-add unit, once per cycle in which it is used. A new request
// is taken only in idle, after the last result is registered for output. A
// zero bound skips rejection sampling; any other bound takes k seed steps,
// each through a multiply state and a compare state, where k is the number
// of steps rejection sampling needs (at least one, under two on average).
module bounded_lcg_random_int_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] max_value, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_value
);
    import blri_pkg::*;

    blri_state_t state_reg, state_next;
    logic [31:0] seed_reg, seed_next;
    logic [30:0] bound_reg, bound_next;
    logic [4:0]  shamt_reg, shamt_next;
    logic [30:0] cand_reg, cand_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] lcg_next;
    logic [30:0] cand_calc;
    logic [30:0] bound_in;
    logic        out_free;

    assign lcg_next  = 32'(seed_reg * LCG_MUL) + LCG_ADD;
    assign cand_calc = seed_reg[30:0] >> shamt_reg;
    assign bound_in  = (s_tdata[30:0] > BOUND_LIMIT) ? BOUND_LIMIT : s_tdata[30:0];
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = (bound_reg == '0) ? S_SIGN : S_STEP;
            end
            S_STEP:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = (cand_calc > bound_reg) ? S_STEP : S_SIGN;
            end
            S_SIGN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        seed_next      = seed_reg;
        bound_next     = bound_reg;
        shamt_next     = shamt_reg;
        cand_next      = cand_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                bound_next = bound_in;
            end
            S_SETUP:
            begin
                shamt_next = shift_for(bound_reg);
                cand_next  = '0;
            end
            S_STEP:
            begin
                seed_next = lcg_next;
            end
            S_CHECK:
            begin
                cand_next = cand_calc;
            end
            S_SIGN:
            begin
                seed_next = lcg_next;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = seed_reg[SIGN_BIT] ? {1'b0, cand_reg}
                                                        : 32'd0 - {1'b0, cand_reg};
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= 32'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg    <= bound_next;
        shamt_reg    <= shamt_next;
        cand_reg     <= cand_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_SETUP)
        else $error("accepted request did not start setup");

    a_cand_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK && state_next == S_SIGN |-> cand_calc <= bound_reg)
        else $error("candidate above bound was kept");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> shamt_reg >= 5'd1)
        else $error("candidate width out of range");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free |=> m_tvalid && state_reg == S_IDLE)
        else $error("finished result not presented");

endmodule

@@ bench/bounded_lcg_random_int_top_tb.sv @@
module bounded_lcg_random_int_top_tb;

    import blri_pkg::*;

    typedef struct {
        logic [30:0] bound;
        bit          drain;
    } bound_req_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    bound_req_t  bound_q[$];
    logic [31:0] value_q[$];
    logic [31:0] gen_seed = 32'd1;
    int          mismatch_count = 0;

    int          burst_left = 0;
    int          gap_left = 0;

    rx_mode_t    rx_mode = RX_OPEN;
    int          seg_left = 0;
    int          hold_left = 0;
    bit          long_hold_done = 1'b0;
    int          results_seen = 0;
    int unsigned rx_cycle = 0;

    bounded_lcg_random_int_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Advances the generator seed the way the block does and returns the signed draw.
    function automatic logic [31:0] draw_value(input logic [30:0] req_bound);
        logic [30:0] lim;
        logic [30:0] cand;
        int          nbits;
        lim = (req_bound > BOUND_LIMIT) ? BOUND_LIMIT : req_bound;
        nbits = 1;
        while (nbits < 31 && (32'd1 << nbits) < {1'b0, lim})
        begin
            nbits++;
        end
        cand = '0;
        if (lim != '0)
        begin
            do
            begin
                gen_seed = gen_seed * LCG_MUL + LCG_ADD;
                cand = gen_seed[30:0] >> (31 - nbits);
            end
            while (cand > lim);
        end
        gen_seed = gen_seed * LCG_MUL + LCG_ADD;
        if (gen_seed[SIGN_BIT])
        begin
            return {1'b0, cand};
        end
        return 32'd0 - {1'b0, cand};
    endfunction

    function automatic bound_req_t make_req(input logic [30:0] b, input bit d);
        bound_req_t r;
        r.bound = b;
        r.drain = d;
        return r;
    endfunction

    function automatic logic [30:0] random_bound();
        int unsigned kind;
        int unsigned k;
        logic [31:0] base;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3:
            begin
                return 31'($urandom_range(0, 64));
            end
            4, 5:
            begin
                k = $urandom_range(0, 30);
                base = (32'd1 << k) + 32'($urandom_range(0, 2)) - 32'd1;
                return base[30:0];
            end
            6, 7:
            begin
                return 31'($urandom());
            end
            default:
            begin
                return 31'($urandom_range(0, 32'h4000_0000));
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bit          offer;
        logic [30:0] next_bound;
        bound_req_t  nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gen_seed = 32'd1;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            offer = 1'b0;
            next_bound = s_tdata[30:0];
            if (s_tvalid && s_tready)
            begin
                value_q.push_back(draw_value(s_tdata[30:0]));
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (bound_q.size() > 0 && !(bound_q[0].drain && value_q.size() > 0))
                begin
                    nxt = bound_q.pop_front();
                    next_bound = nxt.bound;
                    offer = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                s_tvalid <= offer;
                s_tdata <= {1'b0, next_bound};
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] exp_value;
        bit          rdy;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (value_q.size() == 0)
                begin
                    $error("random_value: expected none, actual %0d", $signed(m_tdata));
                    mismatch_count++;
                end
                else
                begin
                    exp_value = value_q.pop_front();
                    if (m_tdata !== exp_value)
                    begin
                        $error("random_value: expected %0d, actual %0d",
                               $signed(exp_value), $signed(m_tdata));
                        mismatch_count++;
                    end
                end
            end
            if (!long_hold_done && results_seen == 200)
            begin
                long_hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(10, 60);
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                end
                else
                begin
                    seg_left--;
                end
                case (rx_mode)
                    RX_OPEN:     rdy = 1'b1;
                    RX_COIN:     rdy = $urandom_range(0, 1) == 1;
                    RX_SPARSE:   rdy = $urandom_range(0, 4) == 0;
                    default:     rdy = rx_cycle[2:0] != 3'd0;
                endcase
            end
            m_tready <= rdy;
        end
    end

    initial
    begin
        logic [30:0] directed[$];
        directed = '{31'd0, 31'd1, 31'd0, 31'd2, 31'd3, 31'd4, 31'd5, 31'd7, 31'd8, 31'd9,
                     31'h2000_0000, 31'h2000_0001, 31'h3fff_ffff, 31'h4000_0000,
                     31'h4000_0001, 31'h7fff_ffff, 31'h5555_5555, 31'h2aaa_aaaa,
                     31'd1, 31'd1, 31'd0, 31'd1, 31'd65535, 31'd65537};
        foreach (directed[i])
        begin
            bound_q.push_back(make_req(directed[i], 1'b0));
        end
        for (int i = 0; i < 800; i++)
        begin
            bound_q.push_back(make_req(random_bound(),
                                       i == 0 || i == 500 || $urandom_range(0, 99) == 0));
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (bound_q.size() > 0 || s_tvalid || value_q.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/blri_pkg.sv
hw/rtl/bounded_lcg_random_int_top.sv
bench/bounded_lcg_random_int_top_tb.sv
